// ===== hw/rtl/pmx_pkg.sv =====
// Shared types, constants and sizes of the XML stream path matcher.
`timescale 1ns / 1ps
package pmx_pkg;

   localparam int PATH_DEPTH = 4;
   localparam int NAME_BYTES = 16;
   localparam int TBL_SIZE   = PATH_DEPTH * NAME_BYTES;
   localparam int LVL_W      = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam int LVLC_W     = $clog2(PATH_DEPTH + 1);
   localparam int NAME_W     = $clog2(NAME_BYTES);
   localparam int LEN_W      = $clog2(NAME_BYTES + 1);
   localparam int ADDR_W     = $clog2(TBL_SIZE);
   localparam int CNT_W      = $clog2(TBL_SIZE + 1);

   // Configuration register indexes.
   localparam logic CSR_TREE_MODE = 1'b0;
   localparam logic CSR_ATTRIB    = 1'b1;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_EXCL  = 8'h21;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      REQ_PARSE   = 2'd0,
      REQ_WRITE   = 2'd1,
      REQ_COMMIT  = 2'd2,
      REQ_RESTART = 2'd3
   } pmx_req_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PARSE,
      OP_COMMIT,
      OP_RESTART
   } pmx_op_type;

   typedef enum logic [3:0] {
      PS_UNINIT   = 4'd0,
      PS_ROOT     = 4'd1,
      PS_PRO_TAG  = 4'd2,
      PS_PRO_NAME = 4'd3,
      PS_PRO_ATTR = 4'd4,
      PS_PRO_END  = 4'd5,
      PS_START    = 4'd6,
      PS_NAME     = 4'd7,
      PS_ATTR     = 4'd8,
      PS_ATTR_VAL = 4'd9,
      PS_CONTENT  = 4'd10,
      PS_END      = 4'd11,
      PS_COMMENT  = 4'd12,
      PS_COMPLETE = 4'd13
   } pmx_pstate_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_SWEEP,
      SEQ_FIN
   } pmx_seq_type;

   typedef struct packed {
      pmx_op_type        op;
      logic [7:0]        ch;
      logic [LVLC_W-1:0] keep;
      logic [LVLC_W-1:0] num;
      logic              sub;
   } pmx_cmd_type;

   typedef struct packed {
      logic [LVLC_W-1:0] matched;
      logic [LVLC_W-1:0] active_levels;
      logic [7:0]        char_pos;
   } pmx_status_type;

   typedef struct packed {
      logic       path_matched;
      logic [7:0] char_out;
      logic       value_char;
      logic       attrib_char;
      logic       clear_strings;
      logic       value_done;
      logic [3:0] parse_state;
   } pmx_result_type;

endpackage

// ===== hw/rtl/pmx_path_store.sv =====
// Staging and active path name memories with registered reads.
`timescale 1ns / 1ps
module pmx_path_store (
   input  logic                      clock,
   input  logic                      stg_we,
   input  logic [pmx_pkg::ADDR_W-1:0] stg_waddr,
   input  logic [7:0]                stg_wdata,
   input  logic                      act_we,
   input  logic [pmx_pkg::ADDR_W-1:0] act_waddr,
   input  logic [7:0]                act_wdata,
   input  logic [pmx_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                act_q_ff,
   output logic [7:0]                stg_q_ff
);
   import pmx_pkg::*;

   logic [7:0] stg_mem_ff [TBL_SIZE];
   logic [7:0] act_mem_ff [TBL_SIZE];

   always_ff @(posedge clock) begin
      if (stg_we) begin
         stg_mem_ff[stg_waddr] <= stg_wdata;
      end
      stg_q_ff <= stg_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem_ff[act_waddr] <= act_wdata;
      end
      act_q_ff <= act_mem_ff[rd_addr];
   end

endmodule

// ===== hw/rtl/pmx_char_engine.sv =====
// Parser state registers and the per-character update and result logic.
`timescale 1ns / 1ps
module pmx_char_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  pmx_pkg::pmx_cmd_type        cmd,
   input  logic                        tree_mode,
   input  logic                        attrib_enable,
   input  logic [7:0]                  name_byte,
   input  logic [pmx_pkg::LEN_W-1:0]   name_len,
   output pmx_pkg::pmx_status_type     status,
   output pmx_pkg::pmx_result_type     result
);
   import pmx_pkg::*;

   pmx_pstate_type    state_ff, state_in, st;
   logic [7:0]        depth_ff, depth_in;
   logic [7:0]        sub_base_ff, sub_base_in;
   logic [LVLC_W-1:0] matched_ff, matched_in;
   logic [LEN_W-1:0]  nmc_ff, nmc_in;
   logic [7:0]        cpos_ff, cpos_in;
   logic              tree_ff, tree_in;
   logic              sub_pend_ff, sub_pend_in;
   logic [LVLC_W-1:0] act_lv_ff, act_lv_in;
   logic signed [9:0] rel, rel_post, lv;
   logic              lvl_match, byte_match;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   assign rel = $signed({2'b0, depth_ff}) - $signed({2'b0, sub_base_ff});
   assign lv  = $signed({{(10 - LVLC_W){1'b0}}, act_lv_ff});

   // The tag name just closed equals the next path level.
   assign lvl_match = (matched_ff < act_lv_ff) && ({{(8 - LEN_W){1'b0}}, nmc_ff} == cpos_ff)
                      && (sub_pend_ff || rel < lv) && (nmc_ff == name_len);

   assign byte_match = (nmc_ff == cpos_ff[LEN_W-1:0]) && (cpos_ff[7:LEN_W] == '0)
                       && (sub_pend_ff || rel < lv) && (matched_ff < act_lv_ff)
                       && (cpos_ff < {{(8 - LEN_W){1'b0}}, name_len})
                       && (cmd.ch == name_byte);

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      sub_base_in = sub_base_ff;
      matched_in  = matched_ff;
      nmc_in      = nmc_ff;
      cpos_in     = cpos_ff;
      tree_in     = tree_ff;
      sub_pend_in = sub_pend_ff;
      act_lv_in   = act_lv_ff;
      st          = state_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_RESTART: begin
            state_in    = PS_UNINIT;
            sub_pend_in = 1'b0;
            cpos_in     = '0;
            tree_in     = 1'b0;
            nmc_in      = '0;
            depth_in    = '0;
            sub_base_in = '0;
            matched_in  = '0;
         end
         OP_COMMIT: begin
            nmc_in     = '0;
            matched_in = cmd.keep;
            act_lv_in  = cmd.num;
            if (sub_base_ff == '0) begin
               sub_pend_in = cmd.sub;
            end
         end
         OP_PARSE: begin
            if (state_ff == PS_UNINIT && cmd.ch == CH_LT) begin
               state_in = PS_ROOT;
            end
            st = state_in;
            if (st != PS_UNINIT && st != PS_COMPLETE) begin
               unique case (cmd.ch)
                  CH_LT: begin
                     if (matched_ff < act_lv_ff) begin
                        tree_in = 1'b0;
                     end else if (tree_mode) begin
                        tree_in = 1'b1;
                     end
                     if (st == PS_ROOT || st == PS_CONTENT) begin
                        state_in = PS_START;
                     end
                     cpos_in = '0;
                     nmc_in  = '0;
                  end
                  CH_GT: begin
                     if (matched_ff < act_lv_ff) begin
                        tree_in = 1'b0;
                     end
                     if (st == PS_NAME || st == PS_ATTR) begin
                        if (lvl_match) begin
                           matched_in = matched_ff + 1'b1;
                           if (sub_pend_ff) begin
                              sub_pend_in = 1'b0;
                              sub_base_in = depth_ff;
                           end
                        end
                        depth_in = sat_inc(depth_ff);
                        state_in = PS_CONTENT;
                     end else if (st == PS_END) begin
                        if (rel == $signed({{(10 - LVLC_W){1'b0}}, matched_ff})
                            && matched_ff != '0) begin
                           matched_in = matched_ff - 1'b1;
                        end
                        if (depth_ff != '0) begin
                           depth_in = depth_ff - 8'd1;
                        end
                        state_in = (depth_in != '0) ? PS_CONTENT : PS_ROOT;
                     end else if (depth_ff == '0 && st == PS_PRO_END) begin
                        state_in = PS_ROOT;
                     end else if (st == PS_COMMENT) begin
                        state_in = (depth_ff == '0) ? PS_ROOT : PS_CONTENT;
                     end
                     cpos_in = '0;
                     nmc_in  = '0;
                  end
                  CH_QM: begin
                     if (matched_ff < act_lv_ff) begin
                        tree_in = 1'b0;
                     end
                     if (st == PS_START && depth_ff == '0) begin
                        state_in = PS_PRO_TAG;
                     end else if (st == PS_PRO_NAME || st == PS_PRO_ATTR) begin
                        state_in = PS_PRO_END;
                     end
                  end
                  CH_EXCL: begin
                     if (st == PS_START) begin
                        state_in = PS_COMMENT;
                     end
                  end
                  CH_DQ, CH_SQ: begin
                     if ($signed({2'b0, depth_ff}) < lv) begin
                        tree_in = 1'b0;
                     end
                     cpos_in = sat_inc(cpos_ff);
                     if (st == PS_ATTR) begin
                        state_in = PS_ATTR_VAL;
                        cpos_in  = sat_inc(sat_inc(cpos_ff));
                     end else if (st == PS_ATTR_VAL) begin
                        state_in = PS_ATTR;
                        cpos_in  = sat_inc(sat_inc(cpos_ff));
                     end
                  end
                  CH_SLASH: begin
                     if (st == PS_START) begin
                        state_in = PS_END;
                     end else if (st == PS_NAME) begin
                        if (lvl_match) begin
                           matched_in = matched_ff + 1'b1;
                           if (sub_pend_ff) begin
                              sub_pend_in = 1'b0;
                              sub_base_in = depth_ff;
                           end
                           cpos_in = '0;
                        end
                        depth_in = sat_inc(depth_ff);
                        state_in = PS_END;
                     end else if (st == PS_ATTR) begin
                        depth_in = sat_inc(depth_ff);
                        state_in = PS_END;
                     end else if (st == PS_CONTENT) begin
                        cpos_in = sat_inc(cpos_ff);
                     end
                  end
                  CH_SP, CH_TAB, CH_CR, CH_LF: begin
                     if (rel < lv) begin
                        tree_in = 1'b0;
                     end
                     if (st == PS_NAME) begin
                        if (lvl_match) begin
                           matched_in = matched_ff + 1'b1;
                           if (sub_pend_ff) begin
                              sub_pend_in = 1'b0;
                              sub_base_in = depth_ff;
                           end
                        end
                        state_in = PS_ATTR;
                        cpos_in  = '0;
                     end else if (st == PS_PRO_NAME) begin
                        state_in = PS_PRO_ATTR;
                     end else if (st == PS_ATTR || st == PS_ATTR_VAL) begin
                        cpos_in = sat_inc(cpos_ff);
                     end
                  end
                  default: begin
                     if (rel < lv || (tree_mode && st == PS_END
                         && rel == $signed({{(10 - LVLC_W){1'b0}}, matched_ff}))) begin
                        tree_in = 1'b0;
                     end else if (tree_mode && matched_ff == act_lv_ff) begin
                        tree_in = 1'b1;
                     end
                     if (st == PS_START) begin
                        state_in = PS_NAME;
                     end else if (st == PS_PRO_TAG) begin
                        state_in = PS_PRO_NAME;
                     end
                     if (state_in == PS_NAME && byte_match) begin
                        nmc_in = nmc_ff + 1'b1;
                     end
                     cpos_in = sat_inc(cpos_ff);
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign rel_post = $signed({2'b0, depth_in}) - $signed({2'b0, sub_base_in});

   always_comb begin
      result               = '0;
      result.path_matched  = (matched_in == act_lv_in);
      result.parse_state   = state_in;
      if (cmd.op == OP_PARSE) begin
         result.char_out = cmd.ch;
         if (matched_in == act_lv_in) begin
            if (tree_mode) begin
               if (tree_in) begin
                  result.value_char = 1'b1;
                  if (state_in == PS_END
                      && rel_post == $signed({{(10 - LVLC_W){1'b0}}, matched_in})) begin
                     result.value_done = 1'b1;
                  end
               end
            end else if (state_in == PS_CONTENT && cpos_in != '0) begin
               result.value_char = 1'b1;
            end else if (state_in == PS_END && cpos_in == '0) begin
               result.value_done = 1'b1;
            end
            if (attrib_enable && (state_in == PS_ATTR || state_in == PS_ATTR_VAL)
                && cpos_in != '0 && matched_in != '0
                && rel_post == $signed({{(10 - LVLC_W){1'b0}}, matched_in - 1'b1})) begin
               result.attrib_char = 1'b1;
               if (cmd.ch == CH_TAB || cmd.ch == CH_CR || cmd.ch == CH_LF) begin
                  result.char_out = CH_SP;
               end
            end
         end else if (rel_post == $signed({{(10 - LVLC_W){1'b0}}, matched_in})
                      && state_in == PS_START && cpos_in == '0) begin
            result.clear_strings = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PS_UNINIT;
         depth_ff    <= '0;
         sub_base_ff <= '0;
         matched_ff  <= '0;
         nmc_ff      <= '0;
         cpos_ff     <= '0;
         tree_ff     <= 1'b0;
         sub_pend_ff <= 1'b0;
         act_lv_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         sub_base_ff <= sub_base_in;
         matched_ff  <= matched_in;
         nmc_ff      <= nmc_in;
         cpos_ff     <= cpos_in;
         tree_ff     <= tree_in;
         sub_pend_ff <= sub_pend_in;
         act_lv_ff   <= act_lv_in;
      end
   end

   assign status.matched       = matched_ff;
   assign status.active_levels = act_lv_ff;
   assign status.char_pos      = cpos_ff;

   a_matched_in_path: assert property (@(posedge clock) disable iff (reset)
      matched_ff <= act_lv_ff) else $error("matched levels exceed path length");

   a_levels_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(act_lv_ff) <= PATH_DEPTH) else $error("path length above table depth");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(nmc_ff) <= NAME_BYTES) else $error("name match count past name size");

endmodule

// ===== hw/rtl/xml_stream_path_matcher.sv =====
// A parse item is registered, executed in the EXEC step and its result registered into the
// result word; one item at a time. Staging writes and restarts take the same path; the next
// word is taken once the result register is free. A path commit walks both name memories
// one entry per cycle, copying staging into active, and then loads its result in the FIN step.
// Synchronous active-high reset clears the parser, the path length and the output valid;
// name memories are not cleared and must be written before a path uses them.
`timescale 1ns / 1ps
module xml_stream_path_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_in[7:0], path_level[9:8], name_index[13:10], path_len[16:14], sub_flag[17]
   input  logic [23:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // path_matched[0], char_out[8:1], value_char[9], attrib_char[10],
   // clear_strings[11], value_done[12], parse_state[16:13]
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import pmx_pkg::*;

   pmx_seq_type       seq_ff, seq_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   pmx_req_type       type_ff;
   logic [7:0]        ch_ff;
   logic [LVL_W-1:0]  wlvl_ff;
   logic [NAME_W-1:0] widx_ff;
   logic              wok_ff;
   logic [LVLC_W-1:0] num_ff;
   logic              sub_ff;
   logic              tree_mode_ff, attrib_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pmx_result_type    rsp_ff;
   logic              accept, load_rsp;

   logic [LEN_W-1:0]  len_ff [PATH_DEPTH];
   logic [LVLC_W-1:0] keep_ff, keep_in;
   logic              cont_ff, cont_in;
   logic              ok_ff, ok_in;
   logic              done_ff, done_in;
   logic              zseen_ff, zseen_in;
   logic [LEN_W-1:0]  lacc_ff, lacc_in;
   logic              sweep_data;
   logic [ADDR_W-1:0] proc_addr;
   logic [LVL_W-1:0]  proc_lvl;
   logic [NAME_W-1:0] proc_idx;
   logic              lvl_end;
   logic [LVLC_W-1:0] lim;

   pmx_cmd_type       cmd;
   pmx_status_type    status;
   pmx_result_type    result;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        act_q, stg_q;
   logic [LEN_W-1:0]  cur_len;

   assign accept = req_tvalid && req_tready;

   // Sequencer: next state.
   always_comb begin
      seq_in = seq_ff;
      cnt_in = cnt_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               seq_in = (pmx_req_type'(req_tuser) == REQ_COMMIT) ? SEQ_SWEEP : SEQ_EXEC;
            end
         end
         SEQ_EXEC: seq_in = SEQ_IDLE;
         SEQ_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == TBL_SIZE) begin
               seq_in = SEQ_FIN;
            end
         end
         SEQ_FIN: seq_in = SEQ_IDLE;
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.ch     = ch_ff;
      cmd.keep   = keep_ff;
      cmd.num    = num_ff;
      cmd.sub    = sub_ff;
      rd_addr    = {status.matched[LVL_W-1:0], status.char_pos[NAME_W-1:0]};
      unique case (seq_ff)
         SEQ_IDLE: req_tready = !rsp_valid_ff || rsp_tready;
         SEQ_EXEC: begin
            load_rsp = 1'b1;
            unique case (type_ff)
               REQ_PARSE:   cmd.op = OP_PARSE;
               REQ_RESTART: cmd.op = OP_RESTART;
               REQ_WRITE:   cmd.op = OP_NONE;
               REQ_COMMIT:  cmd.op = OP_NONE;
               default:     cmd.op = OP_NONE;
            endcase
         end
         SEQ_SWEEP: rd_addr = cnt_ff[ADDR_W-1:0];
         SEQ_FIN: begin
            load_rsp = 1'b1;
            cmd.op   = OP_COMMIT;
         end
         default: begin
         end
      endcase
   end

   // Commit walk: read data of the previous address is compared and copied.
   assign sweep_data = (seq_ff == SEQ_SWEEP) && (cnt_ff != '0);
   assign proc_addr  = ADDR_W'(cnt_ff - 1'b1);
   assign proc_lvl   = proc_addr[ADDR_W-1:NAME_W];
   assign proc_idx   = proc_addr[NAME_W-1:0];
   assign lvl_end    = (int'(proc_idx) == NAME_BYTES - 1);

   always_comb begin
      lim = num_ff;
      if (status.active_levels < lim) begin
         lim = status.active_levels;
      end
      if (status.matched < lim) begin
         lim = status.matched;
      end
   end

   always_comb begin
      ok_in    = (proc_idx == '0) ? 1'b1 : ok_ff;
      done_in  = (proc_idx == '0) ? 1'b0 : done_ff;
      zseen_in = (proc_idx == '0) ? 1'b0 : zseen_ff;
      lacc_in  = (proc_idx == '0) ? LEN_W'(NAME_BYTES) : lacc_ff;
      keep_in  = keep_ff;
      cont_in  = cont_ff;
      if (!done_in) begin
         if (stg_q != act_q) begin
            ok_in   = 1'b0;
            done_in = 1'b1;
         end else if (stg_q == 8'h00) begin
            done_in = 1'b1;
         end
      end
      if (!zseen_in && stg_q == 8'h00) begin
         zseen_in = 1'b1;
         lacc_in  = LEN_W'(proc_idx);
      end
      // A level counts as kept only while every level before it was kept.
      if (lvl_end) begin
         if (LVLC_W'(proc_lvl) < lim && cont_ff && ok_in) begin
            keep_in = keep_ff + 1'b1;
         end else begin
            cont_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         keep_ff <= '0;
         cont_ff <= 1'b1;
      end else if (sweep_data) begin
         keep_ff <= keep_in;
         cont_ff <= cont_in;
      end
      if (sweep_data) begin
         ok_ff    <= ok_in;
         done_ff  <= done_in;
         zseen_ff <= zseen_in;
         lacc_ff  <= lacc_in;
         if (lvl_end) begin
            len_ff[proc_lvl] <= lacc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= pmx_req_type'(req_tuser);
         ch_ff   <= req_tdata[7:0];
         wlvl_ff <= req_tdata[8 +: LVL_W];
         widx_ff <= req_tdata[10 +: NAME_W];
         wok_ff  <= (int'(req_tdata[9:8]) < PATH_DEPTH) && (int'(req_tdata[13:10]) < NAME_BYTES);
         num_ff  <= (int'(req_tdata[16:14]) > PATH_DEPTH) ? LVLC_W'(PATH_DEPTH)
                                                          : LVLC_W'(req_tdata[16:14]);
         sub_ff  <= req_tdata[17];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         cnt_ff       <= '0;
         tree_mode_ff <= 1'b0;
         attrib_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_TREE_MODE) begin
            tree_mode_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_ATTRIB) begin
            attrib_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= result;
      end
   end

   assign cur_len = len_ff[status.matched[LVL_W-1:0]];

   pmx_path_store u_store (
      .clock     (clock),
      .stg_we    ((seq_ff == SEQ_EXEC) && (type_ff == REQ_WRITE) && wok_ff),
      .stg_waddr ({wlvl_ff, widx_ff}),
      .stg_wdata (ch_ff),
      .act_we    (sweep_data),
      .act_waddr (proc_addr),
      .act_wdata (stg_q),
      .rd_addr   (rd_addr),
      .act_q_ff  (act_q),
      .stg_q_ff  (stg_q)
   );

   pmx_char_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .tree_mode     (tree_mode_ff),
      .attrib_enable (attrib_ff),
      .name_byte     (act_q),
      .name_len      (cur_len),
      .status        (status),
      .result        (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.parse_state, rsp_ff.value_done, rsp_ff.clear_strings,
                        rsp_ff.attrib_char, rsp_ff.value_char, rsp_ff.char_out,
                        rsp_ff.path_matched};

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_SWEEP && int'(cnt_ff) == TBL_SIZE) |=> seq_ff == SEQ_FIN)
      else $error("commit walk did not finish");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(seq_ff) == SEQ_EXEC || $past(seq_ff) == SEQ_FIN))
      else $error("result word raised outside an execute step");

   a_commit_walks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == REQ_COMMIT) |=> seq_ff == SEQ_SWEEP && !rsp_valid_in)
      else $error("commit did not start the table walk");

endmodule
